@@ design/mfd_pkg.sv @@
// Shared types for the mixed fraction divider: sequencer states, datapath ops and handshake structs.
package mfd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_N,
        ST_MUL_D,
        ST_GCD,
        ST_GFIX,
        ST_DIV_N,
        ST_DIV_D,
        ST_DIV_W,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_GCD,
        OP_FIX,
        OP_DIV,
        OP_EMIT
    } t_op;

    // operand set for a shift-add multiply
    typedef enum logic [1:0] {
        MSEL_AIMP,
        MSEL_BIMP,
        MSEL_NUM,
        MSEL_DEN
    } t_msel;

    // operand set for a restoring divide
    typedef enum logic [1:0] {
        DSEL_NUM,
        DSEL_DEN,
        DSEL_MIX
    } t_dsel;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        t_dsel dsel;
        logic  first;
        logic  last;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic in_err;
        logic u_zero;
        logic gcd_eq;
        logic k_zero;
        logic out_free;
    } t_stat;

endpackage

@@ design/mfd_alu.sv @@
// Shared add/subtract unit used by the multiply, GCD and divide steps.
module mfd_alu #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic [3*FIELD_WIDTH:0] i_a,
    input  logic [3*FIELD_WIDTH:0] i_b,
    input  logic                   i_sub,
    output logic [3*FIELD_WIDTH:0] o_res,
    output logic                   o_borrow
);
    localparam int AW = 3 * FIELD_WIDTH + 1;

    logic [AW:0] w_full;

    assign w_full   = i_sub ? ({1'b0, i_a} - {1'b0, i_b}) : ({1'b0, i_a} + {1'b0, i_b});
    assign o_res    = w_full[AW-1:0];
    assign o_borrow = i_sub & w_full[AW];

endmodule

@@ design/mfd_seq.sv @@
// Sequencer: steps the shared unit through multiply, GCD, fix-up and divide phases.
module mfd_seq #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mfd_pkg::t_stat i_stat,
    output mfd_pkg::t_ctrl o_ctrl,
    output logic           o_in_ready
);
    localparam int DW = 3 * FIELD_WIDTH;
    localparam int CW = $clog2(DW + 1);

    mfd_pkg::t_state r_state;
    mfd_pkg::t_state n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            w_mul_last;
    logic            w_div_last;

    assign w_mul_last = (r_cnt == CW'(FIELD_WIDTH));
    assign w_div_last = (r_cnt == CW'(DW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CW'(1);
        case (r_state)
            mfd_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_stat.in_fire) begin
                    n_state = i_stat.in_err ? mfd_pkg::ST_EMIT : mfd_pkg::ST_MUL_A;
                end
            end
            mfd_pkg::ST_MUL_A: begin
                if (w_mul_last) begin
                    n_state = mfd_pkg::ST_MUL_B;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_MUL_B: begin
                if (w_mul_last) begin
                    n_state = mfd_pkg::ST_MUL_N;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_MUL_N: begin
                if (w_mul_last) begin
                    n_state = mfd_pkg::ST_MUL_D;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_MUL_D: begin
                if (w_mul_last) begin
                    n_state = mfd_pkg::ST_GCD;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_GCD: begin
                n_cnt = '0;
                if (i_stat.u_zero) begin
                    n_state = mfd_pkg::ST_EMIT;
                end else if (i_stat.gcd_eq) begin
                    n_state = mfd_pkg::ST_GFIX;
                end
            end
            mfd_pkg::ST_GFIX: begin
                n_cnt = '0;
                if (i_stat.k_zero) begin
                    n_state = mfd_pkg::ST_DIV_N;
                end
            end
            mfd_pkg::ST_DIV_N: begin
                if (w_div_last) begin
                    n_state = mfd_pkg::ST_DIV_D;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_DIV_D: begin
                if (w_div_last) begin
                    n_state = mfd_pkg::ST_DIV_W;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_DIV_W: begin
                if (w_div_last) begin
                    n_state = mfd_pkg::ST_EMIT;
                    n_cnt   = '0;
                end
            end
            mfd_pkg::ST_EMIT: begin
                n_cnt = '0;
                if (i_stat.out_free) begin
                    n_state = mfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mfd_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_ctrl.op    = mfd_pkg::OP_NONE;
        o_ctrl.msel  = mfd_pkg::MSEL_AIMP;
        o_ctrl.dsel  = mfd_pkg::DSEL_NUM;
        o_ctrl.first = (r_cnt == '0);
        o_ctrl.last  = 1'b0;
        o_in_ready   = 1'b0;
        case (r_state)
            mfd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            mfd_pkg::ST_MUL_A: begin
                o_ctrl.op   = mfd_pkg::OP_MUL;
                o_ctrl.msel = mfd_pkg::MSEL_AIMP;
                o_ctrl.last = w_mul_last;
            end
            mfd_pkg::ST_MUL_B: begin
                o_ctrl.op   = mfd_pkg::OP_MUL;
                o_ctrl.msel = mfd_pkg::MSEL_BIMP;
                o_ctrl.last = w_mul_last;
            end
            mfd_pkg::ST_MUL_N: begin
                o_ctrl.op   = mfd_pkg::OP_MUL;
                o_ctrl.msel = mfd_pkg::MSEL_NUM;
                o_ctrl.last = w_mul_last;
            end
            mfd_pkg::ST_MUL_D: begin
                o_ctrl.op   = mfd_pkg::OP_MUL;
                o_ctrl.msel = mfd_pkg::MSEL_DEN;
                o_ctrl.last = w_mul_last;
            end
            mfd_pkg::ST_GCD: begin
                o_ctrl.op = mfd_pkg::OP_GCD;
            end
            mfd_pkg::ST_GFIX: begin
                o_ctrl.op = mfd_pkg::OP_FIX;
            end
            mfd_pkg::ST_DIV_N: begin
                o_ctrl.op   = mfd_pkg::OP_DIV;
                o_ctrl.dsel = mfd_pkg::DSEL_NUM;
                o_ctrl.last = w_div_last;
            end
            mfd_pkg::ST_DIV_D: begin
                o_ctrl.op   = mfd_pkg::OP_DIV;
                o_ctrl.dsel = mfd_pkg::DSEL_DEN;
                o_ctrl.last = w_div_last;
            end
            mfd_pkg::ST_DIV_W: begin
                o_ctrl.op   = mfd_pkg::OP_DIV;
                o_ctrl.dsel = mfd_pkg::DSEL_MIX;
                o_ctrl.last = w_div_last;
            end
            mfd_pkg::ST_EMIT: begin
                o_ctrl.op = mfd_pkg::OP_EMIT;
            end
            default: begin
                o_ctrl.op = mfd_pkg::OP_NONE;
            end
        endcase
    end

endmodule

@@ design/mixed_fraction_divider.sv @@
// Top level of the mixed fraction divider: datapath registers, shared unit and sequencer.
// Each item steps through four shift-add multiplies, a binary GCD, fix-up shifts that
// restore the common factor of two, three restoring divides and an emit step, all on
// the single shared unit.
// Throughput: one item at a time; input ready only between items, while a result may wait.
// Error items go straight to the emit step, zero dividends leave the GCD for it. Reset (i_rst_n low) idles it.
module mixed_fraction_divider #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [FIELD_WIDTH-1:0]   i_dividend_whole,
    input  logic [FIELD_WIDTH-1:0]   i_dividend_num,
    input  logic [FIELD_WIDTH-1:0]   i_dividend_den,
    input  logic [FIELD_WIDTH-1:0]   i_divisor_whole,
    input  logic [FIELD_WIDTH-1:0]   i_divisor_num,
    input  logic [FIELD_WIDTH-1:0]   i_divisor_den,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [3*FIELD_WIDTH-1:0] o_quotient_whole,
    output logic [3*FIELD_WIDTH-1:0] o_quotient_num,
    output logic [3*FIELD_WIDTH-1:0] o_quotient_den,
    output logic                     o_div_error
);
    localparam int W  = FIELD_WIDTH;
    localparam int DW = 3 * FIELD_WIDTH;
    localparam int KW = $clog2(DW);

    mfd_pkg::t_ctrl w_ctrl;
    mfd_pkg::t_stat w_stat;

    // input copies
    logic [W-1:0]  r_aw, r_an, r_ad, r_bw, r_bn, r_bd;
    logic          r_err;
    logic          r_zero;
    // working registers
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_sh;
    logic [W-1:0]  r_mp;
    logic [DW-1:0] r_p, r_q, r_u, r_v;
    logic [KW-1:0] r_k;
    // result slot
    logic [DW-1:0] r_ow, r_on, r_od;
    logic          r_oerr;
    logic          r_ovalid;

    logic          w_in_fire;
    logic          w_in_err;
    logic          w_out_free;
    logic          w_u_zero;
    logic          w_gcd_eq;
    logic [DW:0]   w_alu_a;
    logic [DW:0]   w_alu_b;
    logic          w_alu_sub;
    logic [DW:0]   w_alu_res;
    logic          w_alu_borrow;
    logic [DW-1:0] w_dsr;
    logic [DW-1:0] n_acc;
    logic [DW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    assign w_in_fire  = i_in_valid & o_in_ready;
    assign w_in_err   = (i_dividend_den == '0) || (i_divisor_den == '0)
                     || ((i_divisor_whole == '0) && (i_divisor_num == '0));
    assign w_out_free = ~r_ovalid | i_out_ready;
    assign w_u_zero   = (r_u == '0);
    assign w_gcd_eq   = (w_alu_res == '0);

    assign w_stat.in_fire  = w_in_fire;
    assign w_stat.in_err   = w_in_err;
    assign w_stat.u_zero   = w_u_zero;
    assign w_stat.gcd_eq   = w_gcd_eq;
    assign w_stat.k_zero   = (r_k == '0);
    assign w_stat.out_free = w_out_free;

    mfd_seq #(
        .FIELD_WIDTH(FIELD_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_in_ready (o_in_ready)
    );

    assign w_dsr = (w_ctrl.dsel == mfd_pkg::DSEL_MIX) ? r_q : r_u;

    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (w_ctrl.op)
            mfd_pkg::OP_MUL: begin
                w_alu_a = {1'b0, r_acc};
                w_alu_b = {1'b0, r_sh};
            end
            mfd_pkg::OP_GCD: begin
                w_alu_a   = {1'b0, r_u};
                w_alu_b   = {1'b0, r_v};
                w_alu_sub = 1'b1;
            end
            mfd_pkg::OP_DIV: begin
                w_alu_a   = {r_acc, r_sh[DW-1]};
                w_alu_b   = {1'b0, w_dsr};
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_sub = 1'b0;
            end
        endcase
    end

    mfd_alu #(
        .FIELD_WIDTH(FIELD_WIDTH)
    ) u_alu (
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .i_sub    (w_alu_sub),
        .o_res    (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    assign n_acc = r_mp[0] ? w_alu_res[DW-1:0] : r_acc;
    // restore on borrow: keep the shifted partial remainder
    assign n_rem = w_alu_borrow ? {r_acc[DW-2:0], r_sh[DW-1]} : w_alu_res[DW-1:0];
    assign n_quo = {r_sh[DW-2:0], ~w_alu_borrow};

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_aw   <= i_dividend_whole;
            r_an   <= i_dividend_num;
            r_ad   <= i_dividend_den;
            r_bw   <= i_divisor_whole;
            r_bn   <= i_divisor_num;
            r_bd   <= i_divisor_den;
            r_err  <= w_in_err;
            r_zero <= 1'b0;
        end
        case (w_ctrl.op)
            mfd_pkg::OP_MUL: begin
                if (w_ctrl.first) begin
                    case (w_ctrl.msel)
                        mfd_pkg::MSEL_AIMP: begin
                            r_acc <= DW'(r_an);
                            r_sh  <= DW'(r_aw);
                            r_mp  <= r_ad;
                        end
                        mfd_pkg::MSEL_BIMP: begin
                            r_acc <= DW'(r_bn);
                            r_sh  <= DW'(r_bw);
                            r_mp  <= r_bd;
                        end
                        mfd_pkg::MSEL_NUM: begin
                            r_acc <= '0;
                            r_sh  <= r_p;
                            r_mp  <= r_bd;
                        end
                        default: begin
                            r_acc <= '0;
                            r_sh  <= r_q;
                            r_mp  <= r_ad;
                        end
                    endcase
                end else begin
                    r_acc <= n_acc;
                    r_sh  <= {r_sh[DW-2:0], 1'b0};
                    r_mp  <= {1'b0, r_mp[W-1:1]};
                    if (w_ctrl.last) begin
                        case (w_ctrl.msel)
                            mfd_pkg::MSEL_AIMP: r_p <= n_acc;
                            mfd_pkg::MSEL_BIMP: r_q <= n_acc;
                            mfd_pkg::MSEL_NUM:  r_p <= n_acc;
                            default: begin
                                r_q <= n_acc;
                                r_u <= r_p;
                                r_v <= n_acc;
                                r_k <= '0;
                            end
                        endcase
                    end
                end
            end
            mfd_pkg::OP_GCD: begin
                if (w_u_zero) begin
                    r_zero <= 1'b1;
                end else if (!w_gcd_eq) begin
                    if (!r_u[0] && !r_v[0]) begin
                        r_u <= {1'b0, r_u[DW-1:1]};
                        r_v <= {1'b0, r_v[DW-1:1]};
                        r_k <= r_k + KW'(1);
                    end else if (!r_u[0]) begin
                        r_u <= {1'b0, r_u[DW-1:1]};
                    end else if (!r_v[0]) begin
                        r_v <= {1'b0, r_v[DW-1:1]};
                    end else if (w_alu_borrow) begin
                        // swap so the next step subtracts the smaller one
                        r_u <= r_v;
                        r_v <= r_u;
                    end else begin
                        r_u <= w_alu_res[DW-1:0];
                    end
                end
            end
            mfd_pkg::OP_FIX: begin
                // restore the common factor of two
                if (r_k != '0) begin
                    r_u <= {r_u[DW-2:0], 1'b0};
                    r_k <= r_k - KW'(1);
                end
            end
            mfd_pkg::OP_DIV: begin
                if (w_ctrl.first) begin
                    r_acc <= '0;
                    r_sh  <= (w_ctrl.dsel == mfd_pkg::DSEL_DEN) ? r_q : r_p;
                end else begin
                    r_acc <= n_rem;
                    r_sh  <= n_quo;
                    if (w_ctrl.last) begin
                        case (w_ctrl.dsel)
                            mfd_pkg::DSEL_NUM: r_p <= n_quo;
                            mfd_pkg::DSEL_DEN: r_q <= n_quo;
                            default: ;
                        endcase
                    end
                end
            end
            mfd_pkg::OP_EMIT: begin
                if (w_out_free) begin
                    r_ow   <= (r_err || r_zero) ? '0 : r_sh;
                    r_on   <= (r_err || r_zero) ? '0 : r_acc;
                    r_od   <= r_err ? '0 : (r_zero ? DW'(1) : r_q);
                    r_oerr <= r_err;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((w_ctrl.op == mfd_pkg::OP_EMIT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_quotient_whole = r_ow;
    assign o_quotient_num   = r_on;
    assign o_quotient_den   = r_od;
    assign o_div_error      = r_oerr;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    a_proper_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_div_error) |-> (o_quotient_num < o_quotient_den))
        else $error("result numerator not below denominator");

    a_error_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_div_error) |->
        ((o_quotient_whole == '0) && (o_quotient_num == '0) && (o_quotient_den == '0)))
        else $error("error beat carries nonzero fields");

    a_gcd_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_ctrl.op == mfd_pkg::OP_GCD) && !w_u_zero) |-> (r_v != '0))
        else $error("GCD operand went to zero");

endmodule
